// ===== hdl/cir_pkg.sv =====
// ============================================================================
// cir_pkg
// Shared widths, constants and types of the cubic interpolation resampler.
// ============================================================================
package cir_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int FRAC_BITS    = 16;
    localparam int RATIO_WIDTH  = 21;

    // phase carries one extra bit while a run adds the ratio on top of one
    localparam int PHASE_W      = RATIO_WIDTH + 1;
    localparam int MAX_RUN      = 64;
    localparam int RUN_W        = $clog2(MAX_RUN + 1);

    // cubic coefficients: sums of up to four samples
    localparam int COEF_W       = SAMPLE_WIDTH + 3;
    localparam int ACC_W        = COEF_W + FRAC_BITS + 5;
    localparam int FACT_W       = FRAC_BITS + 2;
    localparam int PROD_W       = ACC_W + FACT_W;
    localparam int HI_W         = ACC_W - FRAC_BITS;

    localparam longint ONE_Q    = longint'(1) << FRAC_BITS;
    localparam longint HALF_Q   = longint'(1) << (FRAC_BITS - 1);
    localparam longint SAT_MAX  = (longint'(1) << (SAMPLE_WIDTH - 1)) - 1;
    localparam longint SAT_MIN  = -SAT_MAX - 1;

    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;
    typedef logic        [RATIO_WIDTH-1:0]  t_ratio;
    typedef logic        [PHASE_W-1:0]      t_phase;
    typedef logic signed [COEF_W-1:0]       t_coef;
    typedef logic signed [ACC_W-1:0]        t_acc;
    typedef logic signed [PROD_W-1:0]       t_prod;

    localparam t_ratio RATIO_RESET = t_ratio'(ONE_Q);

    // head of the sample queue as seen by the back end
    typedef struct packed {
        logic    valid;
        t_sample data;
    } t_q_rd;

endpackage

// ===== hdl/cubic_interpolation_resampler.sv =====
// ============================================================================
// cubic_interpolation_resampler
// Cubic (Horner form) sample rate converter with a fixed-point phase.
// ============================================================================
//  channel   direction  handshake                  payload
//  input     in         i_in_valid / o_in_stall    i_in_sample
//  output    out        o_out_valid / i_out_stall  o_out_sample, o_last_of_run
//  config    in         i_cfg_wr_en                i_cfg_wr_data (step ratio)
//
//  each input sample is shifted into the history, turned into coefficients and yields
//  n results (0..64); each result takes three passes through the single multiplier
//  plus rounding and the phase test; a two-entry queue takes samples meanwhile
//  sync reset clears history, phase, queue and the ratio (back to 1.0)
//  a stalled output holds the engine at its rounding step, input stalls when
//  the queue is full
// ============================================================================
module cubic_interpolation_resampler (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  cir_pkg::t_sample i_in_sample,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output cir_pkg::t_sample o_out_sample,
    output logic             o_last_of_run,
    input  logic             i_cfg_wr_en,
    input  cir_pkg::t_ratio  i_cfg_wr_data
);
    import cir_pkg::*;

    t_ratio  r_step_ratio;
    logic    w_q_full;
    logic    w_q_pop;
    t_q_rd   w_q_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_ratio <= RATIO_RESET;
        end else if (i_cfg_wr_en) begin
            r_step_ratio <= i_cfg_wr_data;
        end
    end

    assign o_in_stall = w_q_full;

    cir_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_data  (i_in_sample),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_rd    (w_q_rd)
    );

    cir_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q           (w_q_rd),
        .o_q_pop       (w_q_pop),
        .i_step_ratio  (r_step_ratio),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_sample  (o_out_sample),
        .o_last_of_run (o_last_of_run)
    );

endmodule

// ===== hdl/cir_queue.sv =====
// ============================================================================
// cir_queue
// Short sample queue between the accepting front end and the cubic engine.
// ============================================================================
module cir_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cir_pkg::t_sample i_data,
    output logic            o_full,
    input  logic            i_pop,
    output cir_pkg::t_q_rd  o_rd
);
    import cir_pkg::*;

    t_sample             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;

    logic                w_push;
    logic                w_pop;

    assign o_full     = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign w_push     = i_push && !o_full;
    assign w_pop      = i_pop && (r_count != '0);
    assign o_rd.valid = (r_count != '0);
    assign o_rd.data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

// ===== hdl/cir_engine.sv =====
// ============================================================================
// cir_engine
// Back end: history, phase loop and a Horner sequencer around one multiplier.
// ============================================================================
module cir_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cir_pkg::t_q_rd   i_q,
    output logic             o_q_pop,
    input  cir_pkg::t_ratio  i_step_ratio,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output cir_pkg::t_sample o_out_sample,
    output logic             o_last_of_run
);
    import cir_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COEF,
        ST_CHECK,
        ST_MUL,
        ST_ADD,
        ST_ROUND
    } t_state;

    t_state             r_state;
    t_sample            r_hist [4];
    t_coef              r_coef [4];
    t_acc               r_acc;
    t_prod              r_prod;
    logic [1:0]         r_k;
    t_phase             r_phase;
    logic [RUN_W-1:0]   r_run;
    logic               r_out_valid;
    t_sample            r_out_sample;
    logic               r_last;

    t_coef              w_h [4];
    t_coef              w_a;
    t_coef              w_b;
    t_coef              w_c;
    logic signed [FACT_W-1:0] w_f;
    t_prod              n_prod;
    t_prod              w_prod_shift;
    logic [1:0]         w_idx;
    t_acc               n_acc_add;
    t_acc               w_rnd;
    logic signed [HI_W-1:0] w_hi;
    t_sample            n_out_sample;
    t_phase             n_phase_add;
    t_phase             w_phase_sub;
    logic               w_run_go;
    logic               w_last;
    logic               w_out_free;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_h[i] = COEF_W'(r_hist[i]);
        end
    end

    assign w_a = w_h[3] - w_h[2] - w_h[0] + w_h[1];
    assign w_b = w_h[0] - w_h[1] - w_a;
    assign w_c = w_h[2] - w_h[0];

    // phase never exceeds one while an evaluation runs
    assign w_f    = $signed({1'b0, r_phase[FRAC_BITS:0]});
    assign n_prod = r_acc * w_f;

    // round(acc * f / one), half up, then add the next coefficient
    assign w_prod_shift = (r_prod + $signed(PROD_W'(HALF_Q))) >>> FRAC_BITS;
    assign w_idx        = r_k + 2'd1;
    assign n_acc_add    = $signed(w_prod_shift[ACC_W-1:0])
                        + (t_acc'(r_coef[w_idx]) <<< FRAC_BITS);

    assign w_rnd = (r_acc + $signed(ACC_W'(HALF_Q))) >>> FRAC_BITS;
    assign w_hi  = $signed(w_rnd[HI_W-1:0]);

    always_comb begin
        if (w_hi > $signed(HI_W'(SAT_MAX))) begin
            n_out_sample = t_sample'(SAT_MAX);
        end else if (w_hi < $signed(HI_W'(SAT_MIN))) begin
            n_out_sample = t_sample'(SAT_MIN);
        end else begin
            n_out_sample = w_hi[SAMPLE_WIDTH-1:0];
        end
    end

    assign n_phase_add = r_phase + PHASE_W'(i_step_ratio);
    assign w_phase_sub = r_phase - PHASE_W'(ONE_Q);
    assign w_run_go    = (r_phase <= PHASE_W'(ONE_Q)) && (r_run < RUN_W'(MAX_RUN));
    assign w_last      = (n_phase_add > PHASE_W'(ONE_Q))
                      || (r_run == RUN_W'(MAX_RUN - 1));
    assign w_out_free  = !r_out_valid || !i_out_stall;

    assign o_q_pop       = (r_state == ST_IDLE) && i_q.valid;
    assign o_out_valid   = r_out_valid;
    assign o_out_sample  = r_out_sample;
    assign o_last_of_run = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= '0;
            r_run       <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_hist[i] <= '0;
            end
        end else begin
            if ((r_state == ST_ROUND) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_q.valid) begin
                        r_hist[0] <= r_hist[1];
                        r_hist[1] <= r_hist[2];
                        r_hist[2] <= r_hist[3];
                        r_hist[3] <= i_q.data;
                        r_state   <= ST_COEF;
                    end
                end
                ST_COEF: begin
                    r_coef[0] <= w_a;
                    r_coef[1] <= w_b;
                    r_coef[2] <= w_c;
                    r_coef[3] <= w_h[1];
                    r_run     <= '0;
                    r_state   <= ST_CHECK;
                end
                ST_CHECK: begin
                    if (w_run_go) begin
                        r_acc   <= t_acc'(r_coef[0]) <<< FRAC_BITS;
                        r_k     <= '0;
                        r_state <= ST_MUL;
                    end else begin
                        // take one off the phase, floor at zero
                        if (r_phase >= PHASE_W'(ONE_Q)) begin
                            r_phase <= PHASE_W'(w_phase_sub[RATIO_WIDTH-1:0]);
                        end else begin
                            r_phase <= '0;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                ST_MUL: begin
                    r_prod  <= n_prod;
                    r_state <= ST_ADD;
                end
                ST_ADD: begin
                    r_acc <= n_acc_add;
                    r_k   <= r_k + 2'd1;
                    if (r_k == 2'd2) begin
                        r_state <= ST_ROUND;
                    end else begin
                        r_state <= ST_MUL;
                    end
                end
                ST_ROUND: begin
                    if (w_out_free) begin
                        r_out_sample <= n_out_sample;
                        r_last       <= w_last;
                        r_phase      <= n_phase_add;
                        r_run        <= r_run + RUN_W'(1);
                        r_state      <= ST_CHECK;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hdl/cir_checker.sv =====
// ============================================================================
// cir_checker
// Port-level checks of the resampler, bound to the top level.
// ============================================================================
module cir_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_stall,
    input cir_pkg::t_sample i_in_sample,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input cir_pkg::t_sample o_out_sample,
    input logic             o_last_of_run
);

    // no beat can be ready right after reset
    a_out_idle_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");

    // queue comes out of reset empty
    a_in_open_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_in_stall)
        else $error("input stalled right after reset");

    // no result can follow a reset in fewer cycles than the engine needs
    a_no_early_result: assert property (@(posedge i_clk)
        $past(!i_rst_n, 2) |-> !o_out_valid)
        else $error("result appeared too soon after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_out_sample) && $stable(o_last_of_run))
        else $error("stalled output beat changed");

    // a stalled input beat keeps its sample
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_sample))
        else $error("stalled input beat changed");

endmodule

bind cubic_interpolation_resampler cir_checker u_cir_checker (.*);
